// File: rtl/assert_macros.svh
// assertion macros used by the port-level checker
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/pasf_pkg.sv
// package for the ping-pong audio sample feeder: sizes, codes, types, helpers
// no dependencies
package pasf_pkg;

    localparam int BANK_DEPTH = 512;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CNT_W      = $clog2(BANK_DEPTH + 1);
    localparam int MEM_DEPTH  = 2 * BANK_DEPTH;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);

    localparam int SAMPLE_W   = 16;
    localparam int SKIP_W     = 8;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // output queue
    localparam int Q_DEPTH    = 3;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 2;
    localparam int OCC_W      = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_START = 2'd2,
        CMD_HALT  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SKIP_FACTOR = 1'b0,
        CFG_STEREO_MODE = 1'b1
    } cfg_idx_t;

    // where the samples of a result come from
    typedef enum logic [1:0] {
        SRC_ZERO   = 2'd0,
        SRC_HELD   = 2'd1,
        SRC_MONO   = 2'd2,
        SRC_STEREO = 2'd3
    } res_src_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left_out;
        logic [SAMPLE_W-1:0] right_out;
        logic                load_accepted;
        logic                playing;
    } res_t;

    // word index inside a bank, wrapping to word 0 past the end
    function automatic logic [AW-1:0] bank_idx(input logic [CNT_W-1:0] ptr);
        logic [AW-1:0] idx;
        idx = (ptr < CNT_W'(BANK_DEPTH)) ? ptr[AW-1:0] : '0;
        return idx;
    endfunction

    // flat memory address of a word in one of the two banks
    function automatic logic [MEM_AW-1:0] mem_addr(input logic bank, input logic [AW-1:0] idx);
        logic [MEM_AW-1:0] base;
        base = bank ? MEM_AW'(BANK_DEPTH) : '0;
        return base + MEM_AW'(idx);
    endfunction

endpackage

// File: rtl/pasf_if.sv
// valid/ready channel interfaces for the sample feeder items
// depends on pasf_pkg
interface pasf_req_if;
    import pasf_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [SAMPLE_W-1:0] sample_in;
    logic                batch_end;
    logic                start_buffer;

    modport source (output valid, command, sample_in, batch_end, start_buffer, input ready);
    modport sink   (input valid, command, sample_in, batch_end, start_buffer, output ready);
endinterface

interface pasf_rsp_if;
    import pasf_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] left_out;
    logic [SAMPLE_W-1:0] right_out;
    logic                load_accepted;
    logic                playing;

    modport source (output valid, left_out, right_out, load_accepted, playing, input ready);
    modport sink   (input valid, left_out, right_out, load_accepted, playing, output ready);
endinterface

// File: rtl/pingpong_audio_sample_feeder.sv
// top level of the ping-pong audio sample feeder: two sample banks in one memory
// depends on pasf_pkg and the interfaces in pasf_if.sv
//
//  channel   dir   handshake     payload
//  req       in    valid/ready   command, sample_in, batch_end, start_buffer
//  rsp       out   valid/ready   left_out, right_out, load_accepted, playing
//  cfg       in    cfg_we        cfg_index, cfg_data
//
// a stereo tick that fetches a new pair reads both words through the one port of the
// bank memory, one read per cycle, and holds off req.ready for its right-word read.
// results pass through a 3-entry output queue.
// reset clears all control state; bank memory contents are not cleared.
// a full output queue holds off req.ready; results are never dropped.
module pingpong_audio_sample_feeder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pasf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pasf_pkg::CFG_DATA_W-1:0] cfg_data,
    pasf_req_if.sink                        req,
    pasf_rsp_if.source                      rsp
);
    import pasf_pkg::*;

    // configuration
    logic [SKIP_W-1:0] skip_reg;
    logic              stereo_reg;

    // scalar playback state
    logic              bank_reg, bank_next;
    logic [CNT_W-1:0]  rp_reg, rp_next;
    logic [CNT_W-1:0]  pr_reg, pr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [SKIP_W-1:0] rc_reg, rc_next;
    logic              bo_reg, bo_next;
    logic [2*SAMPLE_W-1:0] held_reg;

    // first result stage
    logic              st1_valid_reg;
    res_src_t          st1_src_reg;
    logic              st1_acc_reg;
    logic              st1_play_reg;
    logic [MEM_AW-1:0] st1_addr_r_reg;

    // second result stage (right word of a stereo pair)
    logic                st2_valid_reg;
    logic                st2_acc_reg;
    logic                st2_play_reg;
    logic [SAMPLE_W-1:0] l_hold_reg;

    // bank memory
    logic [SAMPLE_W-1:0] bank_mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                mem_en;
    logic                mem_we;
    logic [MEM_AW-1:0]   mem_a;

    // output queue
    res_t               q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] q_wr_reg;
    logic [Q_PTR_W-1:0] q_rd_reg;
    logic [Q_CNT_W-1:0] q_cnt_reg;
    logic [OCC_W-1:0]   occupancy;

    // accept-side decode
    logic              req_fire;
    logic              rsp_fire;
    cmd_t              cmd;
    res_src_t          acc_src;
    logic              acc_load;
    logic              rd_l_en;
    logic              wr_en;
    logic              do_swap;
    logic [MEM_AW-1:0] addr_l;
    logic [MEM_AW-1:0] addr_r;
    logic [MEM_AW-1:0] addr_w;
    logic [CNT_W-1:0]  rp1;
    logic [CNT_W-1:0]  rp2;
    logic [CNT_W-1:0]  pr1;
    logic              st1_stereo;

    // result push
    logic                  push;
    res_t                  push_res;
    logic                  held_we;
    logic [2*SAMPLE_W-1:0] held_new;

    assign cmd        = cmd_t'(req.command);
    assign st1_stereo = st1_valid_reg && (st1_src_reg == SRC_STEREO);
    assign occupancy  = OCC_W'(q_cnt_reg) + OCC_W'(st1_valid_reg) + OCC_W'(st2_valid_reg);
    assign req.ready  = !st1_stereo && (occupancy < OCC_W'(Q_DEPTH));
    assign req_fire   = req.valid && req.ready;
    assign rsp_fire   = rsp.valid && rsp.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg   <= '0;
            stereo_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SKIP_FACTOR: skip_reg   <= cfg_data[SKIP_W-1:0];
                CFG_STEREO_MODE: stereo_reg <= cfg_data[0];
                default:         skip_reg   <= skip_reg;
            endcase
        end
    end

    // pointer arithmetic for the two reads of a tick and the load write address
    always_comb
    begin
        rp1    = (rp_reg < CNT_W'(BANK_DEPTH)) ? rp_reg + CNT_W'(1) : rp_reg;
        rp2    = (rp1 < CNT_W'(BANK_DEPTH)) ? rp1 + CNT_W'(1) : rp1;
        pr1    = pr_reg - CNT_W'(1);
        addr_l = mem_addr(bank_reg, bank_idx(rp_reg));
        addr_r = mem_addr(bank_reg, bank_idx(rp1));
        addr_w = mem_addr(~bank_reg, fill_reg[AW-1:0]);
    end

    // next scalar state for an accepted item
    always_comb
    begin
        bank_next = bank_reg;
        rp_next   = rp_reg;
        pr_next   = pr_reg;
        fill_next = fill_reg;
        rc_next   = rc_reg;
        bo_next   = bo_reg;
        acc_src   = SRC_ZERO;
        acc_load  = 1'b0;
        rd_l_en   = 1'b0;
        wr_en     = 1'b0;
        do_swap   = 1'b0;
        if (req_fire)
        begin
            unique case (cmd)
                CMD_TICK:
                begin
                    if (pr_reg != '0)
                    begin
                        if (rc_reg == '0)
                        begin
                            rc_next = skip_reg;
                            rd_l_en = 1'b1;
                            if (stereo_reg && (pr1 != '0))
                            begin
                                acc_src = SRC_STEREO;
                                rp_next = rp2;
                                pr_next = pr1 - CNT_W'(1);
                            end
                            else
                            begin
                                acc_src = SRC_MONO;
                                rp_next = rp1;
                                pr_next = pr1;
                            end
                            do_swap = (pr_next == '0) && !bo_reg;
                        end
                        else
                        begin
                            rc_next = rc_reg - SKIP_W'(1);
                            acc_src = SRC_HELD;
                        end
                    end
                end
                CMD_LOAD:
                begin
                    if (bo_reg || (fill_reg == '0))
                    begin
                        if (fill_reg < CNT_W'(BANK_DEPTH))
                        begin
                            wr_en     = 1'b1;
                            fill_next = fill_reg + CNT_W'(1);
                            acc_load  = 1'b1;
                        end
                        if (req.batch_end)
                        begin
                            bo_next = 1'b0;
                            do_swap = (pr_reg == '0);
                        end
                        else
                        begin
                            bo_next = 1'b1;
                        end
                    end
                end
                CMD_START:
                begin
                    bank_next = req.start_buffer;
                    rp_next   = '0;
                    fill_next = '0;
                    rc_next   = skip_reg;
                    bo_next   = 1'b0;
                end
                CMD_HALT:
                begin
                    pr_next = '0;
                end
                default:
                begin
                    pr_next = pr_reg;
                end
            endcase
            if (do_swap)
            begin
                bank_next = ~bank_reg;
                pr_next   = fill_next;
                rp_next   = '0;
                fill_next = '0;
            end
        end
    end

    // scalar state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= 1'b0;
            rp_reg   <= '0;
            pr_reg   <= '0;
            fill_reg <= '0;
            rc_reg   <= '0;
            bo_reg   <= 1'b0;
            held_reg <= '0;
        end
        else
        begin
            bank_reg <= bank_next;
            rp_reg   <= rp_next;
            pr_reg   <= pr_next;
            fill_reg <= fill_next;
            rc_reg   <= rc_next;
            bo_reg   <= bo_next;
            if (held_we)
            begin
                held_reg <= held_new;
            end
        end
    end

    // memory port: right-word read of a stereo pair, else the accepted item's access
    always_comb
    begin
        mem_en = 1'b0;
        mem_we = 1'b0;
        mem_a  = addr_l;
        if (st1_stereo)
        begin
            mem_en = 1'b1;
            mem_a  = st1_addr_r_reg;
        end
        else if (rd_l_en)
        begin
            mem_en = 1'b1;
            mem_a  = addr_l;
        end
        else if (wr_en)
        begin
            mem_en = 1'b1;
            mem_we = 1'b1;
            mem_a  = addr_w;
        end
    end

    // single-port bank memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_en)
        begin
            if (mem_we)
            begin
                bank_mem[mem_a] <= req.sample_in;
            end
            else
            begin
                rd_data_reg <= bank_mem[mem_a];
            end
        end
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end
        else
        begin
            st1_valid_reg <= req_fire;
            st2_valid_reg <= st1_stereo;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            st1_src_reg    <= acc_src;
            st1_acc_reg    <= acc_load;
            st1_play_reg   <= (pr_next != '0);
            st1_addr_r_reg <= addr_r;
        end
        if (st1_stereo)
        begin
            st2_acc_reg  <= st1_acc_reg;
            st2_play_reg <= st1_play_reg;
            l_hold_reg   <= rd_data_reg;
        end
    end

    // form the finished result and the new held pair
    always_comb
    begin
        push     = 1'b0;
        push_res = '0;
        held_we  = 1'b0;
        held_new = {rd_data_reg, rd_data_reg};
        if (st2_valid_reg)
        begin
            push     = 1'b1;
            held_we  = 1'b1;
            held_new = {rd_data_reg, l_hold_reg};
            push_res.left_out      = l_hold_reg;
            push_res.right_out     = rd_data_reg;
            push_res.load_accepted = st2_acc_reg;
            push_res.playing       = st2_play_reg;
        end
        else if (st1_valid_reg)
        begin
            push_res.load_accepted = st1_acc_reg;
            push_res.playing       = st1_play_reg;
            case (st1_src_reg)
                SRC_ZERO:
                begin
                    push = 1'b1;
                end
                SRC_HELD:
                begin
                    push               = 1'b1;
                    push_res.left_out  = held_reg[SAMPLE_W-1:0];
                    push_res.right_out = held_reg[2*SAMPLE_W-1:SAMPLE_W];
                end
                SRC_MONO:
                begin
                    push               = 1'b1;
                    held_we            = 1'b1;
                    push_res.left_out  = rd_data_reg;
                    push_res.right_out = rd_data_reg;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // output queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                q_wr_reg <= (q_wr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : q_wr_reg + Q_PTR_W'(1);
            end
            if (rsp_fire)
            begin
                q_rd_reg <= (q_rd_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : q_rd_reg + Q_PTR_W'(1);
            end
            q_cnt_reg <= q_cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(rsp_fire);
        end
    end

    // output queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[q_wr_reg[Q_PTR_W-1:0]] <= push_res;
        end
    end

    assign rsp.valid         = (q_cnt_reg != '0);
    assign rsp.left_out      = q_reg[q_rd_reg].left_out;
    assign rsp.right_out     = q_reg[q_rd_reg].right_out;
    assign rsp.load_accepted = q_reg[q_rd_reg].load_accepted;
    assign rsp.playing       = q_reg[q_rd_reg].playing;

endmodule

// File: rtl/pasf_checker.sv
// port-level checker for the sample feeder, bound to the top level
// depends on pasf_pkg and assert_macros.svh
`include "assert_macros.svh"

module pasf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [pasf_pkg::SAMPLE_W-1:0] left_out,
    input logic [pasf_pkg::SAMPLE_W-1:0] right_out,
    input logic                          load_accepted,
    input logic                          playing
);
    import pasf_pkg::*;

    logic [OCC_W-1:0] outstanding_reg;
    logic             req_fire;
    logic             rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // items taken in but not yet handed out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + OCC_W'(req_fire) - OCC_W'(rsp_fire);
        end
    end

    // a stalled result holds
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(left_out) && $stable(right_out) && $stable(load_accepted) && $stable(playing))
    // no result without an item behind it
    `ASSERT_IMPLY(a_no_spurious_rsp, clk, rst_n, rsp_valid, outstanding_reg != '0)
    // a full pipeline stops taking items
    `ASSERT_IMPLY(a_backpressure, clk, rst_n, outstanding_reg >= OCC_W'(Q_DEPTH), !req_ready)
    // a stored load word never carries samples
    `ASSERT_IMPLY(a_load_silent, clk, rst_n, rsp_valid && load_accepted, (left_out == '0) && (right_out == '0))

endmodule

bind pingpong_audio_sample_feeder pasf_checker u_pasf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .left_out      (rsp.left_out),
    .right_out     (rsp.right_out),
    .load_accepted (rsp.load_accepted),
    .playing       (rsp.playing)
);
